### hdl/pors_pkg.sv
// Shared types and constants for the photon orbit RK4 stepper.
package pors_pkg;

    localparam int unsigned FIX_W     = 32;
    localparam int unsigned FRAC_W    = 24;
    localparam int unsigned CFG_W     = 31;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OP_W      = FIX_W + 1;
    localparam int unsigned PROD_W    = 2 * OP_W;

    typedef logic signed [FIX_W-1:0] t_fix;
    typedef logic signed [OP_W-1:0]  t_op;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_fix FIX_MAX = 32'sh7FFF_FFFF;
    localparam t_fix FIX_MIN = 32'sh8000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CURV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd2;

    localparam logic [CFG_W-1:0] CURV_RST  = 31'd50331648;
    localparam logic [CFG_W-1:0] UPPER_RST = 31'd8388608;
    localparam logic [CFG_W-1:0] LOWER_RST = 31'd503316;

    // floor(x/6) = floor((floor(x/2) + 3*2^29) / 3) - 2^29
    localparam t_fix DIV_OFFSET = 32'sh6000_0000;
    localparam t_fix DIV_BIAS   = 32'sh2000_0000;
    localparam t_op  DIV3_RECIP = 33'sh0_AAAA_AAAB;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UU,
        S_KUU,
        S_ACC,
        S_HA,
        S_HV,
        S_KU,
        S_DBL_U,
        S_SUM_U,
        S_DBL_V,
        S_SUM_V,
        S_PT_U,
        S_PT_V,
        S_DH,
        S_DM,
        S_DQ,
        S_DA,
        S_FIN
    } t_state;

    function automatic t_fix sat_fix(input logic signed [FIX_W:0] s);
        t_fix r;
        if (s[FIX_W] != s[FIX_W-1]) begin
            r = s[FIX_W] ? FIX_MIN : FIX_MAX;
        end else begin
            r = s[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/photon_orbit_rk4_stepper.sv
// RK4 integrator for u'' = -u + k*u^2 on one shared multiplier and adder.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: u, du, angle, step; tuser: cmd
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: angle, u; tuser: stopped
//  cfg       in   i_cfg_we                       i_cfg_index, i_cfg_data
//
//  A load word, or a step word while halted, gives its result in the cycle after acceptance.
//  A step word runs four derivative evaluations on the one 33x33 multiplier, weighted
//  sums and midpoints on the saturating adder, a divide-by-six through the multiplier
//  for each of u and u', and a last state that advances the angle.
//  Input is not ready while a step runs or while a result waits on a stalled output.
//  Reset clears u, u', angle and step to zero, sets halt and restores register defaults.
module photon_orbit_rk4_stepper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [127:0]                    s_axis_tdata,  // start_u, start_du, start_angle, step_size
    input  logic [0:0]                      s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // out_angle, out_inv_radius
    output logic [0:0]                      m_axis_tuser,  // out_stopped
    input  logic                            i_cfg_we,
    input  logic [pors_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pors_pkg::CFG_W-1:0]      i_cfg_data
);
    import pors_pkg::*;

    localparam logic [1:0] STG_FIRST = 2'd0;
    localparam logic [1:0] STG_THIRD = 2'd2;
    localparam logic [1:0] STG_LAST  = 2'd3;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_k, r_cfg_hi, r_cfg_lo;
    t_fix             r_u, r_v, r_angle;
    logic [CFG_W-1:0] r_h;
    logic             r_halted;
    logic [1:0]       r_stage;
    logic             r_dsel;
    logic             r_out_valid;
    t_fix             r_out_angle, r_out_u;
    logic             r_out_stop;

    t_fix  r_wu, r_wv, r_ku, r_kv, r_su, r_sv, r_t;
    t_prod r_prod;

    logic                    w_in_acc;
    logic signed [41:0]      w_shift;
    t_fix                    w_q, w_q3;
    t_op                     w_ma, w_mb;
    logic                    w_mul_en;
    t_prod                   w_prod;
    t_fix                    w_aa, w_ab;
    logic                    w_sub;
    logic signed [FIX_W:0]   w_sum;
    t_fix                    w_sat;
    logic                    w_out_busy;
    logic                    w_out_set;
    logic                    w_over, w_under;

    assign w_out_busy    = r_out_valid && !m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !w_out_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_set     = (r_state == S_FIN)
                        || (w_in_acc && (s_axis_tuser[0] == CMD_LOAD || r_halted));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_u, r_out_angle};
    assign m_axis_tuser  = r_out_stop;

    // product back to Q8.24, floor then saturate
    assign w_shift = r_prod[PROD_W-1:FRAC_W];
    always_comb begin
        if (w_shift[41:FIX_W-1] == {(42-FIX_W+1){w_shift[FIX_W-1]}}) begin
            w_q = w_shift[FIX_W-1:0];
        end else begin
            w_q = w_shift[41] ? FIX_MIN : FIX_MAX;
        end
    end
    assign w_q3 = {1'b0, r_prod[2*FIX_W-1:FIX_W+1]};

    assign w_prod = w_ma * w_mb;
    assign w_sum  = w_sub ? ({w_aa[FIX_W-1], w_aa} - {w_ab[FIX_W-1], w_ab})
                          : ({w_aa[FIX_W-1], w_aa} + {w_ab[FIX_W-1], w_ab});
    assign w_sat  = sat_fix(w_sum);

    assign w_over  = $signed(r_u) > $signed({1'b0, r_cfg_hi});
    assign w_under = $signed(r_u) < $signed({1'b0, r_cfg_lo});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && s_axis_tuser[0] == CMD_STEP && !r_halted) begin
                    n_state = S_UU;
                end
            end
            S_UU:    n_state = S_KUU;
            S_KUU:   n_state = S_ACC;
            S_ACC:   n_state = S_HA;
            S_HA:    n_state = S_HV;
            S_HV:    n_state = S_KU;
            S_KU: begin
                priority if (r_stage == STG_FIRST) begin
                    n_state = S_PT_U;
                end else if (r_stage == STG_LAST) begin
                    n_state = S_SUM_U;
                end else begin
                    n_state = S_DBL_U;
                end
            end
            S_DBL_U: n_state = S_SUM_U;
            S_SUM_U: n_state = (r_stage == STG_LAST) ? S_SUM_V : S_DBL_V;
            S_DBL_V: n_state = S_SUM_V;
            S_SUM_V: n_state = (r_stage == STG_LAST) ? S_DH : S_PT_U;
            S_PT_U:  n_state = S_PT_V;
            S_PT_V:  n_state = S_UU;
            S_DH:    n_state = S_DM;
            S_DM:    n_state = S_DQ;
            S_DQ:    n_state = S_DA;
            S_DA:    n_state = r_dsel ? S_FIN : S_DH;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b0;
        w_aa     = '0;
        w_ab     = '0;
        w_sub    = 1'b0;
        unique case (r_state)
            S_UU: begin
                w_ma = {r_wu[FIX_W-1], r_wu};
                w_mb = {r_wu[FIX_W-1], r_wu};
                w_mul_en = 1'b1;
            end
            S_KUU: begin
                w_ma = {2'b00, r_cfg_k};
                w_mb = {w_q[FIX_W-1], w_q};
                w_mul_en = 1'b1;
            end
            S_ACC: begin
                w_aa  = w_q;
                w_ab  = r_wu;
                w_sub = 1'b1;
            end
            S_HA: begin
                w_ma = {2'b00, r_h};
                w_mb = {r_t[FIX_W-1], r_t};
                w_mul_en = 1'b1;
            end
            S_HV: begin
                w_ma = {2'b00, r_h};
                w_mb = {r_wv[FIX_W-1], r_wv};
                w_mul_en = 1'b1;
            end
            S_DBL_U: begin
                w_aa = r_ku;
                w_ab = r_ku;
            end
            S_SUM_U: begin
                w_aa = r_su;
                w_ab = (r_stage == STG_LAST) ? r_ku : r_t;
            end
            S_DBL_V: begin
                w_aa = r_kv;
                w_ab = r_kv;
            end
            S_SUM_V: begin
                w_aa = r_sv;
                w_ab = (r_stage == STG_LAST) ? r_kv : r_t;
            end
            S_PT_U: begin
                w_aa = r_u;
                w_ab = (r_stage == STG_THIRD) ? r_ku : (r_ku >>> 1);
            end
            S_PT_V: begin
                w_aa = r_v;
                w_ab = (r_stage == STG_THIRD) ? r_kv : (r_kv >>> 1);
            end
            S_DH: begin
                w_aa = (r_dsel ? r_sv : r_su) >>> 1;
                w_ab = DIV_OFFSET;
            end
            S_DM: begin
                w_ma = {1'b0, r_t};
                w_mb = DIV3_RECIP;
                w_mul_en = 1'b1;
            end
            S_DQ: begin
                w_aa  = w_q3;
                w_ab  = DIV_BIAS;
                w_sub = 1'b1;
            end
            S_DA: begin
                w_aa = r_dsel ? r_v : r_u;
                w_ab = r_t;
            end
            S_FIN: begin
                w_aa = r_angle;
                w_ab = {1'b0, r_h};
            end
            default: begin
                w_aa = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_k     <= CURV_RST;
            r_cfg_hi    <= UPPER_RST;
            r_cfg_lo    <= LOWER_RST;
            r_u         <= '0;
            r_v         <= '0;
            r_angle     <= '0;
            r_h         <= '0;
            r_halted    <= 1'b1;
            r_stage     <= STG_FIRST;
            r_dsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CURV:  r_cfg_k  <= i_cfg_data;
                    REG_UPPER: r_cfg_hi <= i_cfg_data;
                    REG_LOWER: r_cfg_lo <= i_cfg_data;
                    default:   r_cfg_k  <= r_cfg_k;
                endcase
            end
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_stage <= STG_FIRST;
                        r_dsel  <= 1'b0;
                        if (s_axis_tuser[0] == CMD_LOAD) begin
                            r_u      <= s_axis_tdata[31:0];
                            r_v      <= s_axis_tdata[63:32];
                            r_angle  <= s_axis_tdata[95:64];
                            r_h      <= s_axis_tdata[126:96];
                            r_halted <= 1'b0;
                        end
                    end
                end
                S_PT_V: r_stage <= r_stage + 2'd1;
                S_DA: begin
                    r_dsel <= 1'b1;
                    if (r_dsel) begin
                        r_v <= w_sat;
                    end else begin
                        r_u <= w_sat;
                    end
                end
                S_FIN: begin
                    r_angle  <= w_sat;
                    r_halted <= w_over || w_under;
                end
                default: r_stage <= r_stage;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        unique case (r_state)
            S_IDLE: begin
                r_wu <= r_u;
                r_wv <= r_v;
                if (w_in_acc) begin
                    if (s_axis_tuser[0] == CMD_LOAD) begin
                        r_out_angle <= s_axis_tdata[95:64];
                        r_out_u     <= s_axis_tdata[31:0];
                        r_out_stop  <= 1'b0;
                    end else begin
                        r_out_angle <= r_angle;
                        r_out_u     <= r_u;
                        r_out_stop  <= 1'b1;
                    end
                end
            end
            S_ACC:   r_t  <= w_sat;
            S_HV:    r_kv <= w_q;
            S_KU: begin
                r_ku <= w_q;
                if (r_stage == STG_FIRST) begin
                    r_su <= w_q;
                    r_sv <= r_kv;
                end
            end
            S_DBL_U: r_t  <= w_sat;
            S_SUM_U: r_su <= w_sat;
            S_DBL_V: r_t  <= w_sat;
            S_SUM_V: r_sv <= w_sat;
            S_PT_U:  r_wu <= w_sat;
            S_PT_V:  r_wv <= w_sat;
            S_DH:    r_t  <= w_sum[FIX_W-1:0];
            S_DQ:    r_t  <= w_sat;
            S_FIN: begin
                r_out_angle <= w_sat;
                r_out_u     <= r_u;
                r_out_stop  <= w_over || w_under;
            end
            default: r_t <= r_t;
        endcase
    end

endmodule

### hdl/pors_checker.sv
// Port-level assertions for the photon orbit RK4 stepper, with bind.
module pors_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);
    import pors_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_LOAD
        |=> m_axis_tvalid && m_axis_tuser[0] == 1'b0
            && m_axis_tdata[63:32] == $past(s_axis_tdata[31:0])
            && m_axis_tdata[31:0] == $past(s_axis_tdata[95:64]))
        else $error("load word did not echo start values");

    a_busy_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_STEP && !m_axis_tvalid
        |=> !s_axis_tready || m_axis_tvalid)
        else $error("step word neither running nor answered");

endmodule

bind photon_orbit_rk4_stepper pors_checker u_pors_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
